[hdl/mdi_pkg.sv]
// ----------------------------------------------------------------------------
// mdi_pkg
// Shared types, constants and helpers for the metatile dedup indexer: the
// request and result transactions and the packing of a block into its key.
// ----------------------------------------------------------------------------
`default_nettype none

package mdi_pkg;

  // table size and block geometry defaults
  localparam int unsigned MaxEntriesDef = 256;
  localparam int unsigned BlockSideDef  = 2;

  // key layout: four 16-bit tiles plus the collision byte
  localparam int unsigned TileW  = 16;
  localparam int unsigned CollW  = 8;
  localparam int unsigned KeyW   = 4 * TileW + CollW;
  localparam int unsigned IndexW = 8;

  typedef logic [KeyW-1:0] mdi_key_t;

  // request transaction
  typedef struct packed {
    logic             start_level;
    logic [TileW-1:0] tile_nw;
    logic [TileW-1:0] tile_ne;
    logic [TileW-1:0] tile_sw;
    logic [TileW-1:0] tile_se;
    logic [CollW-1:0] collision_code;
  } mdi_req_t;

  // result transaction
  typedef struct packed {
    logic [IndexW-1:0] block_index;
    logic              is_new;
    logic              overflow;
  } mdi_res_t;

  // pack a block into its key; single-tile blocks keep only the top-left tile
  function automatic mdi_key_t mdi_make_key(input mdi_req_t req, input logic full_block);
    mdi_key_t key;
    key = {req.tile_nw, req.tile_ne, req.tile_sw, req.tile_se, req.collision_code};
    if (!full_block) begin
      key = {req.tile_nw, {(3 * TileW){1'b0}}, req.collision_code};
    end
    return key;
  endfunction

endpackage

`default_nettype wire

[hdl/metatile_dedup_indexer_unit.sv]
// A block's lookup scans the stored keys in order; a hit ends the scan early.
// done_o follows the last compare through the done register. busy drops with
// done_o, so a new block is accepted only once the previous result shows. The
// table RAM read port sets the pace: one key per cycle.
// Reset empties the table (entry count to zero); table contents are not cleared.
// The result is a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// metatile_dedup_indexer_unit
// Dictionary of distinct block keys: looks up each block, appends unseen keys
// in order of first appearance and reports index, new-entry and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module metatile_dedup_indexer_unit
  import mdi_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned BLOCK_SIDE  = BlockSideDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  input  wire mdi_req_t req_i,
  output      logic     busy,
  output      logic     done_o,
  output      mdi_res_t res_o
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);

  localparam logic [0:0] ST_IDLE   = 1'b0;
  localparam logic [0:0] ST_SEARCH = 1'b1;

  logic [0:0]     state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic            done_q, done_d;
  mdi_key_t        key_q, key_d;
  mdi_res_t        res_q, res_d;

  logic            accept;
  logic            rd_en;
  logic            wr_en;
  logic            hit;
  logic            miss;
  mdi_key_t        rd_data;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // key table
  mdi_ram #(
    .Width (KeyW),
    .Depth (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[IdxW-1:0]),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[IdxW-1:0]),
    .rd_data_o (rd_data)
  );

  // scan control: issue one read per cycle, compare the previous read
  assign rd_en = (state_q == ST_SEARCH) && (issue_q < count_q);
  assign hit   = (state_q == ST_SEARCH) && cmp_vld_q && (rd_data == key_q);
  assign miss  = (state_q == ST_SEARCH) && !cmp_vld_q && (issue_q == count_q);
  assign wr_en = miss && (count_q != CntMax);

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    done_d    = 1'b0;
    key_d     = key_q;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          key_d   = mdi_make_key(req_i, BLOCK_SIDE >= 2);
          issue_d = '0;
          if (req_i.start_level) begin
            count_d = '0;
          end
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rd_en) begin
          issue_d   = issue_q + CntW'(1);
          cmp_idx_d = issue_q[IdxW-1:0];
          cmp_vld_d = 1'b1;
        end
        if (hit) begin
          res_d.block_index = IndexW'(cmp_idx_q);
          res_d.is_new      = 1'b0;
          res_d.overflow    = 1'b0;
          done_d            = 1'b1;
          state_d           = ST_IDLE;
        end else if (miss) begin
          if (wr_en) begin
            res_d.block_index = IndexW'(count_q[IdxW-1:0]);
            res_d.is_new      = 1'b1;
            res_d.overflow    = 1'b0;
            count_d           = count_q + CntW'(1);
          end else begin
            res_d.block_index = '0;
            res_d.is_new      = 1'b0;
            res_d.overflow    = 1'b1;
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      issue_q   <= '0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    key_q     <= key_d;
    res_q     <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count beyond table size");

  a_done_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_SEARCH)
    else $error("result without a search");

  a_new_not_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.is_new && res_o.overflow))
    else $error("new entry flagged as overflow");

  a_new_index_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.is_new) |-> count_q == CntW'(res_o.block_index) + CntW'(1))
    else $error("new entry index does not match entry count");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |-> count_q == CntMax)
    else $error("overflow with room left in table");

endmodule

`default_nettype wire

[hdl/mdi_ram.sv]
// ----------------------------------------------------------------------------
// mdi_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mdi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output      logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[tb/mdi_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdi_checker
// Watches the request and result channels of the metatile dedup indexer.
// Keeps its own dictionary of block keys, predicts index, new-entry and
// overflow for every accepted block, and compares each result strobe with
// the oldest prediction. Hands the failure count and the number of
// outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------

module mdi_checker
  import mdi_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned BLOCK_SIDE  = BlockSideDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  mdi_req_t req_i,
  input  logic     done_i,
  input  mdi_res_t res_i,
  output int       fail_cnt_o,
  output int       pending_o
);

  // key as seen by the dictionary: collision byte on top, tiles below
  typedef logic [CollW+4*TileW-1:0] dict_key_t;

  dict_key_t   dict_keys [MAX_ENTRIES];
  int unsigned dict_size;
  mdi_res_t    predicted_res_q [$];
  mdi_res_t    oldest_res;
  int          fails;

  // single-tile blocks drop the three other tiles from the key
  function automatic dict_key_t block_key(input mdi_req_t blk);
    dict_key_t key;
    key = {blk.collision_code, blk.tile_nw, blk.tile_ne, blk.tile_sw, blk.tile_se};
    if (BLOCK_SIDE < 2) begin
      key = {blk.collision_code, blk.tile_nw, {(3 * TileW){1'b0}}};
    end
    return key;
  endfunction

  // look up one block, appending it when absent and there is room
  function automatic mdi_res_t dictionary_lookup(input mdi_req_t blk);
    dict_key_t probe;
    mdi_res_t  res;
    probe = block_key(blk);
    res = '0;
    if (blk.start_level) begin
      dict_size = 0;
    end
    for (int unsigned i = 0; i < dict_size; i++) begin
      if (dict_keys[i] == probe) begin
        res.block_index = IndexW'(i);
        return res;
      end
    end
    if (dict_size >= MAX_ENTRIES) begin
      res.overflow = 1'b1;
    end else begin
      dict_keys[dict_size] = probe;
      res.block_index = IndexW'(dict_size);
      res.is_new = 1'b1;
      dict_size++;
    end
    return res;
  endfunction

  // compare result strobes first, then predict the newly accepted block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_size = 0;
      predicted_res_q.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (done_i) begin
        if (predicted_res_q.size() == 0) begin
          $error("result with no block waiting: block_index %0d is_new %0b overflow %0b",
                 res_i.block_index, res_i.is_new, res_i.overflow);
          fails++;
        end else begin
          oldest_res = predicted_res_q.pop_front();
          if (res_i.block_index !== oldest_res.block_index) begin
            $error("block_index: expected %0d, actual %0d",
                   oldest_res.block_index, res_i.block_index);
            fails++;
          end
          if (res_i.is_new !== oldest_res.is_new) begin
            $error("is_new: expected %0b, actual %0b", oldest_res.is_new, res_i.is_new);
            fails++;
          end
          if (res_i.overflow !== oldest_res.overflow) begin
            $error("overflow: expected %0b, actual %0b", oldest_res.overflow, res_i.overflow);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predicted_res_q = {predicted_res_q, dictionary_lookup(req_i)};
      end
      fail_cnt_o <= fails;
      pending_o  <= predicted_res_q.size();
    end
  end

endmodule

[tb/metatile_dedup_indexer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// metatile_dedup_indexer_unit_tb
// Regression for the metatile dedup indexer: directed blocks on field
// extremes, hits, near misses and level restarts, then table fills up to
// overflow and random levels of repeated and fresh keys, with the sender
// idling at several rates. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------

module metatile_dedup_indexer_unit_tb
  import mdi_pkg::*;
();

  localparam int unsigned MaxEntries = MaxEntriesDef;
  localparam int unsigned BlockSide  = BlockSideDef;
  localparam int          BlockGoal  = 1050;
  localparam int          ChunkLen   = 120;
  localparam int          CycleLimit = 1_500_000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  logic     done_o;
  mdi_req_t req_i;
  mdi_res_t res_o;

  int       fail_cnt;
  int       pending_cnt;
  int       cycle_cnt;
  int       blocks_sent;
  int       idle_pct;
  mdi_req_t level_keys [$];

  metatile_dedup_indexer_unit #(
    .MAX_ENTRIES (MaxEntries),
    .BLOCK_SIDE  (BlockSide)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  mdi_checker #(
    .MAX_ENTRIES (MaxEntries),
    .BLOCK_SIDE  (BlockSide)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .req_i      (req_i),
    .done_i     (done_o),
    .res_i      (res_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("metatile_dedup_indexer_unit regression: fail");
      $finish;
    end
  end

  function automatic mdi_req_t make_block(input logic sl, input logic [TileW-1:0] nw,
                                          input logic [TileW-1:0] ne,
                                          input logic [TileW-1:0] sw,
                                          input logic [TileW-1:0] se,
                                          input logic [CollW-1:0] coll);
    mdi_req_t blk;
    blk.start_level    = sl;
    blk.tile_nw        = nw;
    blk.tile_ne        = ne;
    blk.tile_sw        = sw;
    blk.tile_se        = se;
    blk.collision_code = coll;
    return blk;
  endfunction

  // tile codes lean toward the extremes now and then
  function automatic logic [TileW-1:0] rand_tile();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return TileW'($urandom);
    endcase
  endfunction

  function automatic mdi_req_t rand_block();
    return make_block(1'b0, rand_tile(), rand_tile(), rand_tile(), rand_tile(),
                      CollW'($urandom));
  endfunction

  // one request transaction: optional idle gap, then hold start until accepted
  task automatic send_block(input mdi_req_t blk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= blk;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    blocks_sent++;
  endtask

  // fill a fresh level to the brim, then probe the full table
  task automatic fill_dictionary();
    mdi_req_t stored [$];
    mdi_req_t blk;
    for (int i = 0; i < MaxEntries; i++) begin
      blk = rand_block();
      blk.start_level = (i == 0);
      blk.tile_nw = TileW'(i);
      stored = {stored, blk};
      send_block(blk);
    end
    // absent keys overflow, held keys still hit
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 1)) begin
        blk = rand_block();
        blk.tile_nw = TileW'($urandom_range(MaxEntries, 16'hffff));
      end else begin
        blk = stored[$urandom_range(0, MaxEntries - 1)];
        blk.start_level = 1'b0;
      end
      send_block(blk);
    end
    send_block(stored[MaxEntries - 1]);
    blk = stored[0];
    blk.start_level = 1'b0;
    send_block(blk);
    // restart of a level on a full table lands at index zero
    blk = rand_block();
    blk.tile_nw = TileW'($urandom_range(MaxEntries, 16'hffff));
    blk.start_level = 1'b1;
    send_block(blk);
  endtask

  // random levels: mostly repeats and fresh keys, some near misses and restarts
  task automatic send_random_block();
    mdi_req_t blk;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 4 || level_keys.size() == 0) begin
      blk = (level_keys.size() != 0 && $urandom_range(0, 1)) ?
            level_keys[$urandom_range(0, level_keys.size() - 1)] : rand_block();
      level_keys.delete();
      blk.start_level = 1'b1;
      level_keys = {level_keys, blk};
    end else if (pick < 54) begin
      blk = level_keys[$urandom_range(0, level_keys.size() - 1)];
      blk.start_level = 1'b0;
    end else if (pick < 66) begin
      blk = level_keys[$urandom_range(0, level_keys.size() - 1)];
      blk.start_level = 1'b0;
      blk[$urandom_range(0, CollW + 4 * TileW - 1)] ^= 1'b1;
      level_keys = {level_keys, blk};
    end else begin
      blk = rand_block();
      level_keys = {level_keys, blk};
    end
    send_block(blk);
  endtask

  initial begin
    bit refilled;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cycle_cnt   = 0;
    blocks_sent = 0;
    idle_pct    = 0;
    refilled    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, hits, single-field differences, level restarts
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h01));
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 8'h00));
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hfe));
    send_block(make_block(1'b0, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 8'ha5));
    send_block(make_block(1'b0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 8'h5a));
    send_block(make_block(1'b0, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 8'ha5));
    send_block(make_block(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_block(make_block(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    send_block(make_block(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_block(make_block(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));
    send_block(make_block(1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff));

    // full table, overflow and restart on a full table
    fill_dictionary();

    // random part, idle rate rotating per chunk
    while (blocks_sent < BlockGoal) begin
      case ((blocks_sent / ChunkLen) % 3)
        0: idle_pct = 0;
        1: idle_pct = 74;
        default: idle_pct = 34;
      endcase
      if (!refilled && blocks_sent >= 600) begin
        refilled = 1'b1;
        fill_dictionary();
        level_keys.delete();
      end else begin
        send_random_block();
      end
    end
    start <= 1'b0;

    // drain
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (MaxEntries + 4) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("metatile_dedup_indexer_unit regression: pass");
    end else begin
      $display("metatile_dedup_indexer_unit regression: fail");
    end
    $finish;
  end

endmodule
